### src/hbs_pkg.sv
// ----------------------------------------------------------------------------
// hbs_pkg: shared types, constants and functions of the bit-plane scan driver
// holds panel geometry, stream layouts, command/status bundles and helpers
// ----------------------------------------------------------------------------
`default_nettype none

package hbs_pkg;

    // panel geometry
    localparam int COLUMNS    = 32;
    localparam int ROWS       = 8;
    localparam int PLANES     = 8;
    localparam int PLANE_SIZE = ROWS * COLUMNS;

    // frame store: one word per pixel pair, six bits per plane
    localparam int ENTRY_W = 6;
    localparam int WORD_W  = ENTRY_W * PLANES;
    localparam int AW      = $clog2(PLANE_SIZE);

    // counters
    localparam int POS_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS + 1);
    localparam int COL_IW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    // field widths
    localparam int COLOR_W   = 8;
    localparam int INDEX_W   = 8;
    localparam int ROW_W     = 3;
    localparam int PLANE_W   = 3;
    localparam int SLOT_W    = 8;
    localparam int ORDER_W   = 24;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 16;

    // reset values
    localparam logic [ORDER_W-1:0] ROW_ORDER_RESET = 24'd9350264;
    localparam logic [SLOT_W-1:0]  SLOT_RESET      = 8'd255;

    // input function codes (s_tuser)
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_SCAN  = 1'b1;

    // beat kinds (m_tuser)
    localparam logic BEAT_DATA  = 1'b0;
    localparam logic BEAT_LATCH = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic start_scan;
        logic write_pixel;
        logic issue_read;
        logic load_data;
        logic load_latch;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic adv;
        logic f_valid;
        logic reads_done;
    } status_t;

    // plane shown in a slot: highest set bit of the slot number
    function automatic logic [PLANE_W-1:0] top_bit(input logic [SLOT_W-1:0] v);
        logic [PLANE_W-1:0] p;
        p = '0;
        for (int k = 0; k < SLOT_W; k++) begin
            if (v[k]) begin
                p = PLANE_W'(k);
            end
        end
        return p;
    endfunction

    // spread a pixel pair over planes, bit k of each colour into plane k
    function automatic logic [WORD_W-1:0] pack_planes(
        input logic [COLOR_W-1:0] ur,
        input logic [COLOR_W-1:0] ug,
        input logic [COLOR_W-1:0] ub,
        input logic [COLOR_W-1:0] lr,
        input logic [COLOR_W-1:0] lg,
        input logic [COLOR_W-1:0] lb
    );
        logic [WORD_W-1:0] w;
        logic [2:0]        b;
        w = '0;
        for (int p = 0; p < PLANES; p++) begin
            b = 3'(p);
            if (p < COLOR_W) begin
                w[p*ENTRY_W +: ENTRY_W] = {lb[b], lg[b], lr[b], ub[b], ug[b], ur[b]};
            end
        end
        return w;
    endfunction

endpackage

`default_nettype wire

### src/hub75_bitplane_scan_driver.sv
// ----------------------------------------------------------------------------
// hub75_bitplane_scan_driver: hub75 panel driver with bit-plane frame store
// pixel pair writes fill the store, row ticks shift one plane row and latch
// ----------------------------------------------------------------------------
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tuser: func; tdata: index, upper rgb, lower rgb
// m_*      out  m_tvalid/m_tready  tuser: beat_kind; tlast: last; tdata: rgb, row, plane
// cfg_*    in   cfg_valid/cfg_ready cfg_data: row_order
//
// a pixel write is stored at its transfer and input stays ready; a row scan
// runs from its transfer to the next free input through the transfer cycle,
// the registered store read, 32 data beats and the latch beat, with one read
// per cycle from the single read port of the frame store while unstalled
// output stalls freeze the fetch stage; the output register still gives one
// beat per cycle once the consumer takes them
// reset clears control state and the per-entry valid bits, so the store reads
// dark at once with no clearing pass
//
`default_nettype none

module hub75_bitplane_scan_driver (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // slave stream
    input  wire logic                          s_tvalid,
    output      logic                          s_tready,
    // pixel_index, upper_red, upper_green, upper_blue,
    // lower_red, lower_green, lower_blue (8 bits each)
    input  wire logic [hbs_pkg::S_TDATA_W-1:0] s_tdata,
    // func
    input  wire logic                          s_tuser,
    // master stream
    output      logic                          m_tvalid,
    input  wire logic                          m_tready,
    // rgb_bits [5:0], row_address [8:6], plane [11:9], zero fill [15:12]
    output      logic [hbs_pkg::M_TDATA_W-1:0] m_tdata,
    // beat_kind
    output      logic                          m_tuser,
    output      logic                          m_tlast,
    // configuration write
    input  wire logic                          cfg_valid,
    output      logic                          cfg_ready,
    input  wire logic [hbs_pkg::ORDER_W-1:0]   cfg_data
);

    hbs_pkg::cmd_t    cmd;
    hbs_pkg::status_t status;

    // controller
    hbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .func     (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    hbs_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // latch beat ends the scan and carries no colour
    a_latch_beat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == hbs_pkg::BEAT_LATCH) |-> m_tlast && (m_tdata[5:0] == 6'd0))
        else $error("latch beat malformed");

    // a row scan transfer blocks further input on the next cycle
    a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == hbs_pkg::FUNC_SCAN) |=> !s_tready)
        else $error("input accepted during scan");

    // latch is only formed once all column data has drained
    a_latch_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_latch |-> status.reads_done && !status.f_valid && !cmd.issue_read)
        else $error("latch beat before row data done");

endmodule

`default_nettype wire

### src/hbs_ram.sv
// ----------------------------------------------------------------------------
// hbs_ram: generic single-port-write, single-port-read ram
// one write and one registered read per cycle, read data held while re is low
// ----------------------------------------------------------------------------
`default_nettype none

module hbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // storage write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### src/hbs_ctrl.sv
// ----------------------------------------------------------------------------
// hbs_ctrl: scan controller
// accepts items while idle; a scan item then steps the datapath through one row scan
// ----------------------------------------------------------------------------
`default_nettype none

module hbs_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    input  wire logic             func,
    output      logic             s_tready,
    input  wire hbs_pkg::status_t status,
    output      hbs_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (func == hbs_pkg::FUNC_SCAN)
                    begin
                        cmd.start_scan = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    else
                    begin
                        cmd.write_pixel = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (status.adv)
                begin
                    cmd.issue_read = !status.reads_done;
                    if (status.f_valid)
                    begin
                        cmd.load_data = 1'b1;
                    end
                    else if (status.reads_done)
                    begin
                        cmd.load_latch = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/hbs_datapath.sv
// ----------------------------------------------------------------------------
// hbs_datapath: frame store, scan counters and output register
// writes pixel pairs, fetches one row of a plane and forms the beats
// ----------------------------------------------------------------------------
`default_nettype none

module hbs_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire hbs_pkg::cmd_t                     cmd,
    output      hbs_pkg::status_t                  status,
    input  wire logic [hbs_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire logic                              cfg_valid,
    output      logic                              cfg_ready,
    input  wire logic [hbs_pkg::ORDER_W-1:0]       cfg_data,
    input  wire logic                              m_tready,
    output      logic                              m_tvalid,
    output      logic [hbs_pkg::M_TDATA_W-1:0]     m_tdata,
    output      logic                              m_tuser,
    output      logic                              m_tlast
);

    localparam int CW = hbs_pkg::COLOR_W;

    // configuration and scan position state
    logic [hbs_pkg::ORDER_W-1:0]  order_reg;
    logic [hbs_pkg::POS_W-1:0]    pos_reg;
    logic [hbs_pkg::POS_W-1:0]    pos_next;
    logic [hbs_pkg::SLOT_W-1:0]   slot_reg;
    logic [hbs_pkg::SLOT_W-1:0]   slot_next;

    // per-scan context
    logic [hbs_pkg::ROW_W-1:0]    scan_row_reg;
    logic [hbs_pkg::PLANE_W-1:0]  scan_plane_reg;
    logic                         scan_ok_reg;
    logic [2:0]                   entry;
    logic [hbs_pkg::ROW_W-1:0]    next_row;
    logic [hbs_pkg::PLANE_W-1:0]  next_plane;

    // fetch stage
    logic [hbs_pkg::COL_W-1:0]    rd_col_reg;
    logic                         f_valid_reg;
    logic                         rd_vld_reg;
    logic [hbs_pkg::PLANE_SIZE-1:0] vld_reg;

    // frame store ports
    logic                         ram_we;
    logic [hbs_pkg::AW-1:0]       ram_waddr;
    logic [hbs_pkg::WORD_W-1:0]   ram_wdata;
    logic [hbs_pkg::AW-1:0]       ram_raddr;
    logic [hbs_pkg::WORD_W-1:0]   ram_rdata;

    // beat forming
    logic [hbs_pkg::ENTRY_W-1:0]  sel_bits;
    logic [hbs_pkg::ENTRY_W-1:0]  data_bits;

    // output register
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         out_kind_reg;
    logic [hbs_pkg::ENTRY_W-1:0]  out_rgb_reg;
    logic [hbs_pkg::ROW_W-1:0]    out_row_reg;
    logic [hbs_pkg::PLANE_W-1:0]  out_plane_reg;
    logic                         out_last_reg;

    logic [hbs_pkg::INDEX_W-1:0]  pixel_index;

    assign cfg_ready   = 1'b1;
    assign pixel_index = s_tdata[hbs_pkg::INDEX_W-1:0];

    // status back to the controller
    assign status.adv        = !out_valid_reg || m_tready;
    assign status.f_valid    = f_valid_reg;
    assign status.reads_done = (int'(rd_col_reg) == hbs_pkg::COLUMNS);

    // row and plane of the scan about to start
    assign entry      = 3'(pos_reg);
    assign next_row   = order_reg[entry*hbs_pkg::ROW_W +: hbs_pkg::ROW_W];
    assign next_plane = hbs_pkg::top_bit(slot_reg);

    // pixel write into the frame store
    assign ram_we    = cmd.write_pixel && (int'(pixel_index) < hbs_pkg::PLANE_SIZE);
    assign ram_waddr = hbs_pkg::AW'(pixel_index);
    assign ram_wdata = hbs_pkg::pack_planes(
        s_tdata[1*CW +: CW], s_tdata[2*CW +: CW], s_tdata[3*CW +: CW],
        s_tdata[4*CW +: CW], s_tdata[5*CW +: CW], s_tdata[6*CW +: CW]);

    // fetch address: row base plus column
    assign ram_raddr = hbs_pkg::AW'(int'(scan_row_reg) * hbs_pkg::COLUMNS
                                    + int'(rd_col_reg[hbs_pkg::COL_IW-1:0]));

    hbs_ram #(
        .WIDTH (hbs_pkg::WORD_W),
        .DEPTH (hbs_pkg::PLANE_SIZE)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.issue_read),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // plane select from the fetched word, unwritten entries read dark
    always_comb
    begin
        sel_bits = '0;
        for (int p = 0; p < hbs_pkg::PLANES; p++)
        begin
            if (int'(scan_plane_reg) == p)
            begin
                sel_bits = ram_rdata[p*hbs_pkg::ENTRY_W +: hbs_pkg::ENTRY_W];
            end
        end
        data_bits = (scan_ok_reg && rd_vld_reg) ? sel_bits : '0;
    end

    // scan position advances after each latch beat, the modulation slot after the last row's
    always_comb
    begin
        pos_next  = pos_reg;
        slot_next = slot_reg;
        if (cmd.load_latch)
        begin
            if (int'(pos_reg) == hbs_pkg::ROWS - 1)
            begin
                pos_next = '0;
                if (slot_reg <= hbs_pkg::SLOT_W'(1))
                begin
                    slot_next = hbs_pkg::SLOT_RESET;
                end
                else
                begin
                    slot_next = slot_reg - 1'b1;
                end
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    // output valid: set on load, cleared on transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_data || cmd.load_latch)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg     <= hbs_pkg::ROW_ORDER_RESET;
            pos_reg       <= '0;
            slot_reg      <= hbs_pkg::SLOT_RESET;
            rd_col_reg    <= '0;
            f_valid_reg   <= 1'b0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                order_reg <= cfg_data;
            end
            pos_reg       <= pos_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
            if (ram_we)
            begin
                vld_reg[ram_waddr] <= 1'b1;
            end
            if (cmd.start_scan)
            begin
                rd_col_reg  <= '0;
                f_valid_reg <= 1'b0;
            end
            else if (cmd.issue_read)
            begin
                rd_col_reg  <= rd_col_reg + 1'b1;
                f_valid_reg <= 1'b1;
            end
            else if (status.adv)
            begin
                f_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.start_scan)
        begin
            scan_row_reg   <= next_row;
            scan_plane_reg <= next_plane;
            scan_ok_reg    <= (int'(next_row) < hbs_pkg::ROWS)
                              && (int'(next_plane) < hbs_pkg::PLANES);
        end
        if (cmd.issue_read)
        begin
            rd_vld_reg <= vld_reg[ram_raddr];
        end
        if (cmd.load_data)
        begin
            out_kind_reg <= hbs_pkg::BEAT_DATA;
            out_rgb_reg  <= data_bits;
            out_last_reg <= 1'b0;
        end
        else if (cmd.load_latch)
        begin
            out_kind_reg <= hbs_pkg::BEAT_LATCH;
            out_rgb_reg  <= '0;
            out_last_reg <= 1'b1;
        end
        if (cmd.load_data || cmd.load_latch)
        begin
            out_row_reg   <= scan_row_reg;
            out_plane_reg <= scan_plane_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'b0000, out_plane_reg, out_row_reg, out_rgb_reg};

endmodule

`default_nettype wire

### tb/tb_hub75_bitplane_scan_driver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hub75_bitplane_scan_driver: self-checking bench for the bit-plane driver
// pixel pair writes and row scans go in over the slave stream, every beat that
// comes out is compared with a local model of the frame store, the scan order
// and the modulation slot counter; both sides idle and stall at random
// ----------------------------------------------------------------------------
`default_nettype none

module tb_hub75_bitplane_scan_driver;

    localparam int STORE_DEPTH  = hbs_pkg::PLANES * hbs_pkg::PLANE_SIZE;
    localparam int SETTLE_CYCLS = 40;

    // one input command, one output beat
    typedef struct packed {
        logic       func;
        logic [7:0] index;
        logic [7:0] ur;
        logic [7:0] ug;
        logic [7:0] ub;
        logic [7:0] lr;
        logic [7:0] lg;
        logic [7:0] lb;
    } panel_cmd_t;

    typedef struct packed {
        logic       kind;
        logic [5:0] rgb;
        logic [2:0] row;
        logic [2:0] plane;
        logic       last;
    } beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [23:0] cfg_data = '0;

    // shadow copy of the block state
    logic [5:0]  shadow_planes [STORE_DEPTH];
    logic [2:0]  shadow_row_pos;
    logic [7:0]  shadow_slot;
    logic [23:0] shadow_order;

    beat_t pending_beats[$];
    int    fail_count = 0;

    // idling controls shared with the receiver
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    int rx_hold_cycles = 0;

    hub75_bitplane_scan_driver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // plane of a modulation slot: highest set bit
    function automatic logic [2:0] slot_plane(input logic [7:0] slot);
        for (int k = 7; k >= 0; k--) begin
            if (slot[k]) begin
                return 3'(k);
            end
        end
        return 3'd0;
    endfunction

    // apply one accepted command to the shadow state, queue the beats it causes
    task automatic predict_scan_beats(input panel_cmd_t cmd);
        logic [2:0] row;
        logic [2:0] plane;
        logic       lit;
        beat_t      b;
        if (cmd.func == hbs_pkg::FUNC_WRITE) begin
            if (int'(cmd.index) < hbs_pkg::PLANE_SIZE) begin
                for (int k = 0; k < hbs_pkg::PLANES; k++) begin
                    shadow_planes[k * hbs_pkg::PLANE_SIZE + int'(cmd.index)] = (k < 8) ?
                        {cmd.lb[k], cmd.lg[k], cmd.lr[k], cmd.ub[k], cmd.ug[k], cmd.ur[k]}
                        : 6'd0;
                end
            end
        end
        else begin
            row   = shadow_order[3 * (shadow_row_pos % 8) +: 3];
            plane = slot_plane(shadow_slot);
            lit   = (int'(row) < hbs_pkg::ROWS) && (int'(plane) < hbs_pkg::PLANES);
            for (int c = 0; c < hbs_pkg::COLUMNS; c++) begin
                b.kind  = hbs_pkg::BEAT_DATA;
                b.rgb   = lit ? shadow_planes[int'(plane) * hbs_pkg::PLANE_SIZE
                                              + int'(row) * hbs_pkg::COLUMNS + c] : 6'd0;
                b.row   = row;
                b.plane = plane;
                b.last  = 1'b0;
                pending_beats.push_back(b);
            end
            b.kind  = hbs_pkg::BEAT_LATCH;
            b.rgb   = 6'd0;
            b.row   = row;
            b.plane = plane;
            b.last  = 1'b1;
            pending_beats.push_back(b);
            // advance scan position, step the slot once per frame
            if (int'(shadow_row_pos) + 1 >= hbs_pkg::ROWS) begin
                shadow_row_pos = '0;
                shadow_slot    = (shadow_slot <= 8'd1) ? 8'd255 : shadow_slot - 8'd1;
            end
            else begin
                shadow_row_pos = shadow_row_pos + 3'd1;
            end
        end
    endtask

    // present one command and wait for its transfer
    task automatic send_cmd(input panel_cmd_t cmd);
        int gap;
        gap = tx_idle ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd.func;
        s_tdata  <= {cmd.lb, cmd.lg, cmd.lr, cmd.ub, cmd.ug, cmd.ur, cmd.index};
        @(posedge clk);
        while (s_tready !== 1'b1) @(posedge clk);
        predict_scan_beats(cmd);
    endtask

    task automatic send_scan();
        panel_cmd_t cmd;
        cmd      = '0;
        cmd.func = hbs_pkg::FUNC_SCAN;
        send_cmd(cmd);
    endtask

    task automatic send_pixel(input logic [7:0] index, input logic [7:0] ur,
                              input logic [7:0] ug, input logic [7:0] ub,
                              input logic [7:0] lr, input logic [7:0] lg,
                              input logic [7:0] lb);
        panel_cmd_t cmd;
        cmd = {hbs_pkg::FUNC_WRITE, index, ur, ug, ub, lr, lg, lb};
        send_cmd(cmd);
    endtask

    function automatic panel_cmd_t random_cmd(input int write_pct);
        panel_cmd_t cmd;
        cmd.func  = ($urandom_range(0, 99) < write_pct) ? hbs_pkg::FUNC_WRITE
                                                        : hbs_pkg::FUNC_SCAN;
        cmd.index = 8'($urandom);
        cmd.ur    = 8'($urandom);
        cmd.ug    = 8'($urandom);
        cmd.ub    = 8'($urandom);
        cmd.lr    = 8'($urandom);
        cmd.lg    = 8'($urandom);
        cmd.lb    = 8'($urandom);
        return cmd;
    endfunction

    // stop offering, wait for every queued beat, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLS) @(posedge clk);
    endtask

    // row order register write, only from an idle block
    task automatic set_row_order(input logic [23:0] order);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= order;
        @(posedge clk);
        while (cfg_ready !== 1'b1) @(posedge clk);
        cfg_valid    <= 1'b0;
        shadow_order = order;
    endtask

    task automatic check_beat();
        beat_t want;
        if (pending_beats.size() == 0) begin
            $error("beat with no expectation: tdata %h tuser %b tlast %b",
                   m_tdata, m_tuser, m_tlast);
            fail_count++;
            return;
        end
        want = pending_beats.pop_front();
        if (m_tuser !== want.kind) begin
            $error("beat_kind: expected %0d actual %0d", want.kind, m_tuser);
            fail_count++;
        end
        if (m_tdata[5:0] !== want.rgb) begin
            $error("rgb_bits: expected %h actual %h", want.rgb, m_tdata[5:0]);
            fail_count++;
        end
        if (m_tdata[8:6] !== want.row) begin
            $error("row_address: expected %0d actual %0d", want.row, m_tdata[8:6]);
            fail_count++;
        end
        if (m_tdata[11:9] !== want.plane) begin
            $error("plane: expected %0d actual %0d", want.plane, m_tdata[11:9]);
            fail_count++;
        end
        if (m_tdata[15:12] !== 4'd0) begin
            $error("tdata fill: expected 0 actual %h", m_tdata[15:12]);
            fail_count++;
        end
        if (m_tlast !== want.last) begin
            $error("last: expected %0d actual %0d", want.last, m_tlast);
            fail_count++;
        end
    endtask

    // receiver: random stall before each beat, long hold-off on request
    initial begin : beat_monitor
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            stall = rx_idle ? $urandom_range(0, 16) : 0;
            if (rx_hold_cycles > 0) begin
                stall          = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (m_tvalid !== 1'b1) @(posedge clk);
            check_beat();
        end
    end

    // a fresh store reads dark in the default scan order
    task automatic test_dark_after_reset();
        repeat (hbs_pkg::ROWS) send_scan();
        drain();
    endtask

    // colour extremes at the corners of the index range, then one full frame
    task automatic test_pixel_extremes();
        send_pixel(8'd0,   8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF);
        send_pixel(8'd31,  8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00);
        send_pixel(8'd255, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'd224, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55);
        send_pixel(8'd1,   8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA);
        repeat (hbs_pkg::ROWS) send_scan();
        drain();
    endtask

    // two scans on row 0, then two on row 7, then back to the default order
    task automatic test_row_order_extremes();
        set_row_order(24'h000000);
        repeat (2) send_scan();
        set_row_order(24'hFFFFFF);
        repeat (2) send_scan();
        set_row_order(hbs_pkg::ROW_ORDER_RESET);
        drain();
    endtask

    // receiver holds off while scans keep coming, so the input stalls
    task automatic test_output_stall();
        tx_idle        = 1'b0;
        rx_hold_cycles = 700;
        repeat (10) send_scan();
        drain();
        tx_idle = 1'b1;
    endtask

    // random commands in blocks, idling changed between blocks, row order before blocks 2 and 4
    task automatic test_random_traffic();
        for (int blk = 0; blk < 6; blk++) begin
            tx_idle = (blk != 2);
            rx_idle = (blk != 2) && (blk != 4);
            if (blk == 2 || blk == 4) begin
                set_row_order(24'($urandom));
            end
            repeat (34) send_cmd(random_cmd(55));
            drain();
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // full-speed scans over four frames, a write every 16 scans; the slot steps at each frame
    task automatic test_plane_sweep();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        for (int i = 0; i < 4 * hbs_pkg::ROWS; i++) begin
            if (i % 16 == 0) begin
                send_cmd(random_cmd(100));
            end
            send_scan();
        end
        drain();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    initial begin : run_tests
        for (int i = 0; i < STORE_DEPTH; i++) begin
            shadow_planes[i] = '0;
        end
        shadow_row_pos = '0;
        shadow_slot    = hbs_pkg::SLOT_RESET;
        shadow_order   = hbs_pkg::ROW_ORDER_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_dark_after_reset();
        test_pixel_extremes();
        test_row_order_extremes();
        test_output_stall();
        test_random_traffic();
        test_plane_sweep();

        drain();
        if (fail_count == 0) begin
            $display("PASS");
        end
        else begin
            $display("FAIL");
        end
        $finish;
    end

    // run limit
    initial begin : watchdog
        #(10_000_000);
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
src/hbs_pkg.sv
src/hbs_ram.sv
src/hbs_ctrl.sv
src/hbs_datapath.sv
src/hub75_bitplane_scan_driver.sv
tb/tb_hub75_bitplane_scan_driver.sv
